@@ src/lk_pkg.sv @@
`timescale 1ns / 1ps
// Package for the code lock with escalating lockout.
// Holds sizes, reset values, mode/event/register codes and the shared structs.
// No dependencies.
package lk_pkg;

    // Sizes
    localparam int CODE_DIGITS    = 4;
    localparam int DIGIT_REGS     = 4;
    localparam int DIGIT_IDX_BITS = 2;
    localparam int DIAL_BITS      = 8;
    localparam int TIME_BITS      = 24;
    localparam int POS_BITS       = 3;
    localparam int GUESS_BITS     = 5;
    localparam int LOCKOUT_BITS   = 5;
    localparam int LEN_BITS       = 3;
    localparam int MAXG_BITS      = 4;
    localparam int BASE_BITS      = 12;
    localparam int FUNC_BITS      = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 12;

    // Limits and reset values
    localparam int LOCKOUT_MAX       = 31;
    localparam int RELOAD_WAIT       = 10;
    localparam int RESET_CODE_LENGTH = 4;
    localparam int RESET_MAX_GUESSES = 3;
    localparam int RESET_BASE_WAIT   = 10;

    typedef enum logic [1:0] {
        MODE_LOCKED   = 2'd0,
        MODE_UNLOCKED = 2'd1,
        MODE_BLOCKED  = 2'd2
    } t_mode;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_DIAL  = 2'd0,
        FUNC_PRESS = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DIGIT_FIRST  = 3'd0,
        REG_DIGIT_SECOND = 3'd1,
        REG_DIGIT_THIRD  = 3'd2,
        REG_DIGIT_FOURTH = 3'd3,
        REG_CODE_LENGTH  = 3'd4,
        REG_MAX_GUESSES  = 3'd5,
        REG_BASE_WAIT    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [DIGIT_REGS-1:0][DIAL_BITS-1:0] digit;
        logic [LEN_BITS-1:0]                  code_length;
        logic [MAXG_BITS-1:0]                 max_guesses;
        logic [BASE_BITS-1:0]                 base_wait;
    } t_cfg;

    typedef struct packed {
        t_mode                         mode;
        logic [POS_BITS-1:0]           position;
        logic signed [GUESS_BITS-1:0]  guesses;
        logic [LOCKOUT_BITS-1:0]       lockouts;
        logic [TIME_BITS-1:0]          countdown;
        logic [DIAL_BITS-1:0]          dial_held;
    } t_state;

    typedef struct packed {
        t_mode                         mode;
        logic [POS_BITS-1:0]           position;
        logic signed [GUESS_BITS-1:0]  guesses;
        logic [TIME_BITS-1:0]          countdown;
        logic [DIAL_BITS-1:0]          dial_held;
        logic                          refresh;
    } t_result;

endpackage

@@ src/lk_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file for the code lock.
// Depends on lk_pkg.
module lk_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [lk_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [lk_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output lk_pkg::t_cfg                    o_cfg
);
    import lk_pkg::*;

    t_cfg r_cfg;

    // Register writes, decoded by index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digit       <= '0;
            r_cfg.code_length <= LEN_BITS'(RESET_CODE_LENGTH);
            r_cfg.max_guesses <= MAXG_BITS'(RESET_MAX_GUESSES);
            r_cfg.base_wait   <= BASE_BITS'(RESET_BASE_WAIT);
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_DIGIT_FIRST:  r_cfg.digit[0]    <= i_cfg_data[DIAL_BITS-1:0];
                REG_DIGIT_SECOND: r_cfg.digit[1]    <= i_cfg_data[DIAL_BITS-1:0];
                REG_DIGIT_THIRD:  r_cfg.digit[2]    <= i_cfg_data[DIAL_BITS-1:0];
                REG_DIGIT_FOURTH: r_cfg.digit[3]    <= i_cfg_data[DIAL_BITS-1:0];
                REG_CODE_LENGTH:  r_cfg.code_length <= i_cfg_data[LEN_BITS-1:0];
                REG_MAX_GUESSES:  r_cfg.max_guesses <= i_cfg_data[MAXG_BITS-1:0];
                REG_BASE_WAIT:    r_cfg.base_wait   <= i_cfg_data[BASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/lk_core.sv @@
`timescale 1ns / 1ps
// Next-state logic of the code lock: one event in, updated state and refresh out.
// Depends on lk_pkg.
module lk_core (
    input  lk_pkg::t_cfg                 i_cfg,
    input  lk_pkg::t_state               i_state,
    input  logic [lk_pkg::FUNC_BITS-1:0] i_func,
    input  logic [lk_pkg::DIAL_BITS-1:0] i_dial_value,
    output lk_pkg::t_state               o_state,
    output logic                         o_refresh
);
    import lk_pkg::*;

    localparam int SHIFT_BITS = BASE_BITS + (1 << LOCKOUT_BITS) - 1;

    t_func                         func;
    logic [LEN_BITS-1:0]           eff_len;
    logic [DIAL_BITS-1:0]          req_digit;
    logic [POS_BITS:0]             pos_inc;
    logic signed [GUESS_BITS-1:0]  guess_dec;
    logic [SHIFT_BITS-1:0]         shifted;
    logic [TIME_BITS-1:0]          lock_len;
    logic [LOCKOUT_BITS-1:0]       lockouts_inc;

    assign func = t_func'(i_func);

    // Code length: zero counts as one, clamp to the digit count
    always_comb begin
        if (i_cfg.code_length == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (i_cfg.code_length > LEN_BITS'(CODE_DIGITS)) begin
            eff_len = LEN_BITS'(CODE_DIGITS);
        end else begin
            eff_len = i_cfg.code_length;
        end
    end

    // Required digit at the current position; positions without a register need 0
    always_comb begin
        if (i_state.position < POS_BITS'(DIGIT_REGS)) begin
            req_digit = i_cfg.digit[i_state.position[DIGIT_IDX_BITS-1:0]];
        end else begin
            req_digit = '0;
        end
    end

    assign pos_inc   = {1'b0, i_state.position} + (POS_BITS+1)'(1);
    assign guess_dec = i_state.guesses - GUESS_BITS'(1);

    // Lockout length: base_wait << lockouts, saturated to all ones
    assign shifted  = SHIFT_BITS'(i_cfg.base_wait) << i_state.lockouts;
    assign lock_len = (|shifted[SHIFT_BITS-1:TIME_BITS]) ? '1 : shifted[TIME_BITS-1:0];

    assign lockouts_inc = (i_state.lockouts < LOCKOUT_BITS'(LOCKOUT_MAX))
                        ? i_state.lockouts + LOCKOUT_BITS'(1) : i_state.lockouts;

    // Event handling
    always_comb begin
        o_state   = i_state;
        o_refresh = 1'b0;
        unique case (func)
            FUNC_DIAL: begin
                if (i_state.mode == MODE_LOCKED && i_dial_value != i_state.dial_held) begin
                    o_state.dial_held = i_dial_value;
                    o_refresh         = 1'b1;
                end
            end
            FUNC_PRESS: begin
                if (i_state.mode == MODE_LOCKED) begin
                    o_refresh = 1'b1;
                    if (i_state.dial_held == req_digit) begin
                        if (pos_inc >= (POS_BITS+1)'(eff_len)) begin
                            o_state.mode     = MODE_UNLOCKED;
                            o_state.position = '0;
                            o_state.lockouts = '0;
                        end else begin
                            o_state.position = pos_inc[POS_BITS-1:0];
                        end
                    end else begin
                        // wrong digit: restart entry and spend a guess
                        o_state.guesses  = guess_dec;
                        o_state.position = '0;
                        if (guess_dec < 0) begin
                            o_state.mode      = MODE_BLOCKED;
                            o_state.countdown = lock_len;
                            o_state.lockouts  = lockouts_inc;
                        end
                    end
                end else if (i_state.mode == MODE_UNLOCKED) begin
                    o_state.mode     = MODE_LOCKED;
                    o_state.position = '0;
                    o_state.guesses  = $signed({1'b0, i_cfg.max_guesses});
                    o_refresh        = 1'b1;
                end
            end
            FUNC_TICK: begin
                if (i_state.mode == MODE_BLOCKED) begin
                    o_refresh = 1'b1;
                    if (i_state.countdown == '0) begin
                        // lockout expired: relock, restore guesses
                        o_state.mode      = MODE_LOCKED;
                        o_state.position  = '0;
                        o_state.countdown = TIME_BITS'(RELOAD_WAIT);
                        o_state.guesses   = $signed({1'b0, i_cfg.max_guesses});
                    end else begin
                        o_state.countdown = i_state.countdown - TIME_BITS'(1);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/lk_outq.sv @@
`timescale 1ns / 1ps
// Two-entry result queue between the lock state update and the output channel.
// Depends on lk_pkg.
module lk_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lk_pkg::t_result i_data,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop_ready,
    output lk_pkg::t_result o_data
);
    import lk_pkg::*;

    localparam int DEPTH = 2;

    t_result    r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid & i_pop_ready;
    assign o_valid = r_count != 2'd0;
    assign o_ready = r_count != 2'(DEPTH);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

@@ src/code_lock_with_backoff_lockout.sv @@
`timescale 1ns / 1ps
// Code lock with escalating lockout: top level.
// Each result beat is registered in the result queue when its event is accepted.
// One event beat per cycle unless the queue is full; the update is combinational.
// A two-entry result queue keeps input accepted while one result waits downstream.
// Reset (synchronous, active low): locked, position 0, guesses 3, countdown 10.
module code_lock_with_backoff_lockout (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [lk_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lk_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lk_pkg::FUNC_BITS-1:0]     i_func,
    input  logic [lk_pkg::DIAL_BITS-1:0]     i_dial_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_lock_mode,
    output logic [lk_pkg::POS_BITS-1:0]      o_digits_matched,
    output logic signed [lk_pkg::GUESS_BITS-1:0] o_guesses_left,
    output logic [lk_pkg::TIME_BITS-1:0]     o_seconds_left,
    output logic [lk_pkg::DIAL_BITS-1:0]     o_shown_value,
    output logic                             o_refresh
);
    import lk_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    logic    refresh;
    logic    in_fire;
    t_result result;
    t_result head;

    lk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lk_core u_core (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_func       (i_func),
        .i_dial_value (i_dial_value),
        .o_state      (n_state),
        .o_refresh    (refresh)
    );

    assign in_fire = i_in_valid & o_in_ready;

    // Lock state register, updated once per accepted event beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= MODE_LOCKED;
            r_state.position  <= '0;
            r_state.guesses   <= GUESS_BITS'(RESET_MAX_GUESSES);
            r_state.lockouts  <= '0;
            r_state.countdown <= TIME_BITS'(RESET_BASE_WAIT);
            r_state.dial_held <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result beat built from the post-event state
    always_comb begin
        result.mode      = n_state.mode;
        result.position  = n_state.position;
        result.guesses   = n_state.guesses;
        result.countdown = n_state.countdown;
        result.dial_held = n_state.dial_held;
        result.refresh   = refresh;
    end

    lk_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_fire),
        .i_data      (result),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (head)
    );

    assign o_lock_mode      = head.mode;
    assign o_digits_matched = head.position;
    assign o_guesses_left   = head.guesses;
    assign o_seconds_left   = head.countdown;
    assign o_shown_value    = head.dial_held;
    assign o_refresh        = head.refresh;

    // Checks
    a_blocked_no_guesses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_BLOCKED) |-> (r_state.guesses == '1))
        else $error("blocked mode with guesses other than -1");

    a_pos_only_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode != MODE_LOCKED) |-> (r_state.position == '0))
        else $error("code position held outside locked mode");

    a_unlock_press_relocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_func == FUNC_PRESS && r_state.mode == MODE_UNLOCKED)
        |=> (r_state.mode == MODE_LOCKED))
        else $error("press while unlocked did not relock");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule
